@@ hw/rtl/wtosc_pkg.sv @@
// wtosc_pkg: field widths, register indexes, command codes and datapath
// constants of the wavetable oscillator. No dependencies.
package wtosc_pkg;

  localparam int TABLE_SIZE_DEF  = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int FRAC_BITS = 16;
  localparam int STEP_W    = 26;
  localparam int WEIGHT_W  = 16;
  localparam int HARM_W    = 7;
  localparam int ADDR_W    = 11;
  localparam int DATA_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int CFG_W     = 26;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HARMONIC   = 2'd2;

  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic [WEIGHT_W-1:0] WEIGHT_RST = 16'd32768;
  localparam logic [HARM_W-1:0]   HARM_RST   = 7'd1;

  // interpolated magnitude is at most 2^31, times a 16-bit weight
  localparam int MAG_W      = 32;
  localparam int DIV_W      = MAG_W + WEIGHT_W;
  localparam int DIV_STEP   = 8;
  localparam int DIV_CYCLES = DIV_W / DIV_STEP;

  // gain product is split in two halves of the quotient
  localparam int MUL_SPLIT  = DIV_W / 2;
  localparam int PPROD_W    = MUL_SPLIT + GAIN_W;
  localparam int FULL_W     = DIV_W + GAIN_W;
  localparam int GAIN_SHIFT = 46;
  localparam int RAW_W      = FULL_W - GAIN_SHIFT;

endpackage

@@ hw/rtl/wavetable_interp_oscillator.sv @@
// wavetable_interp_oscillator: wavetable oscillator with linear interpolation
// over a synchronous table memory with one read port and a multi-cycle datapath.
// Depends on wtosc_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transaction.
//   A write command (in_command = 1) stores in_table_data at in_table_address
//   (addresses above TABLE_SIZE are dropped) and produces no result. A sample
//   command (in_command = 0) reads two neighboring table entries at the current
//   phase, interpolates, weights, divides by the harmonic, applies
//   in_envelope_gain and saturates; the result appears on the
//   out_valid/out_ready channel.
//   A new sample transaction is taken only once the previous one has passed
//   two reads through the one table read port, five multiply and scale stages,
//   a divider that retires 8 quotient bits per cycle and the output load.
//   The phase advance (modulo TABLE_SIZE entries) runs beside the datapath.
//   The result sits in an output register; while it waits, the next
//   transaction is accepted and processed, and only the final load waits for
//   the output register to drain. Reset clears phase and control state and
//   loads the register defaults; table contents are undefined until written.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
module wavetable_interp_oscillator #(
  parameter int TABLE_SIZE  = wtosc_pkg::TABLE_SIZE_DEF,
  parameter int SAMPLE_BITS = wtosc_pkg::SAMPLE_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wtosc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wtosc_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [wtosc_pkg::ADDR_W-1:0]        in_table_address,
  input  logic signed [wtosc_pkg::DATA_W-1:0] in_table_data,
  input  logic [wtosc_pkg::GAIN_W-1:0]        in_envelope_gain,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wtosc_pkg::DATA_W-1:0] out_sample
);
  import wtosc_pkg::*;

  localparam int IW   = $clog2(TABLE_SIZE);
  localparam int PW   = IW + FRAC_BITS;
  localparam int AW   = $clog2(TABLE_SIZE + 1);
  localparam int CW   = ((AW > ADDR_W) ? AW : ADDR_W) + 1;
  localparam int SUMW = ((PW > STEP_W) ? PW : STEP_W) + 1;
  localparam longint SPAN     = longint'(TABLE_SIZE) << FRAC_BITS;
  localparam longint STEP_MAX = (longint'(1) << STEP_W) - 1;
  localparam longint QMAX     = (SPAN - 1 + STEP_MAX) / SPAN;
  localparam int QB   = $clog2(QMAX + 1);
  localparam int KW   = (QB > 1) ? $clog2(QB) : 1;
  localparam int SATW = ((RAW_W > SAMPLE_BITS) ? RAW_W : SAMPLE_BITS) + 1;
  localparam int DCW  = $clog2(DIV_CYCLES);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD1  = 4'd1;
  localparam logic [3:0] S_MUL  = 4'd2;
  localparam logic [3:0] S_ABS  = 4'd3;
  localparam logic [3:0] S_WGT  = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_GMUL = 4'd6;
  localparam logic [3:0] S_SUM  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  // configuration registers
  logic [STEP_W-1:0]   step_r;
  logic [WEIGHT_W-1:0] weight_r;
  logic [HARM_W-1:0]   harmonic_r;
  logic [HARM_W-1:0]   harm_eff;

  // control
  logic [3:0]     state_r, state_nxt;
  logic [DCW-1:0] div_cnt_r;
  logic           in_acc, sample_acc, mem_we;
  logic           out_valid_r, out_load;

  // phase and its modulo reduction
  logic [PW-1:0]   phase_r;
  logic            red_busy_r;
  logic [KW-1:0]   red_k_r;
  logic [SUMW-1:0] red_sum_r, red_sum_nxt;
  logic [63:0]     red_sub;

  // table memory
  logic [DATA_W-1:0] table_mem [0:TABLE_SIZE];
  logic [DATA_W-1:0] mem_rd_data_r;
  logic [AW-1:0]     mem_rd_addr, mem_wr_addr;

  // datapath registers
  logic [IW-1:0]        idx_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [GAIN_W-1:0]    gain_r;
  logic [DATA_W-1:0]    v0_r;
  logic signed [DATA_W:0]   diff;
  logic signed [DATA_W:0]   frac_s;
  logic signed [33:0]   p_nxt, p_r;
  logic                 neg_r;
  logic [MAG_W-1:0]     mag_r;
  logic [DIV_W-1:0]     dvd_r, dvd_nxt;
  logic [HARM_W-1:0]    rem_r, rem_nxt;
  logic [DIV_W-1:0]     dv;
  logic [HARM_W-1:0]    rm;
  logic [HARM_W:0]      trial;
  logic [PPROD_W-1:0]   pp_hi_r, pp_lo_r;
  logic [FULL_W-1:0]    full_sum;
  logic [RAW_W-1:0]     raw_r;
  logic [SATW-1:0]      sat_mag, sat_res, max_pos;
  logic [DATA_W-1:0]    out_sample_r;

  assign in_ready   = (state_r == S_IDLE) && !red_busy_r;
  assign in_acc     = in_valid && in_ready;
  assign sample_acc = in_acc && (in_command == CMD_SAMPLE);
  assign mem_we     = in_acc && (in_command == CMD_WRITE) &&
                      (CW'(in_table_address) <= CW'(TABLE_SIZE));
  assign mem_wr_addr = AW'(in_table_address);
  assign mem_rd_addr = (state_r == S_IDLE) ? AW'(phase_r[PW-1:FRAC_BITS])
                                           : AW'(idx_r) + AW'(1);
  assign harm_eff   = (harmonic_r == '0) ? HARM_W'(1) : harmonic_r;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_ready);
  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_wr_addr] <= in_table_data;
    end
    mem_rd_data_r <= table_mem[mem_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r     <= '0;
      weight_r   <= WEIGHT_RST;
      harmonic_r <= HARM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PHASE_STEP: step_r     <= cfg_data[STEP_W-1:0];
        REG_WEIGHT:     weight_r   <= cfg_data[WEIGHT_W-1:0];
        REG_HARMONIC:   harmonic_r <= cfg_data[HARM_W-1:0];
        default: ;
      endcase
    end
  end

  // phase wrap: restoring reduction by SPAN << k, one k per cycle
  always_comb begin
    red_sub     = 64'(SPAN) << red_k_r;
    red_sum_nxt = red_sum_r;
    if (64'(red_sum_r) >= red_sub) begin
      red_sum_nxt = red_sum_r - SUMW'(red_sub);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      red_busy_r <= 1'b0;
      red_k_r    <= '0;
    end else if (sample_acc) begin
      red_busy_r <= 1'b1;
      red_k_r    <= KW'(QB - 1);
    end else if (red_busy_r) begin
      red_k_r <= red_k_r - KW'(1);
      if (red_k_r == '0) begin
        red_busy_r <= 1'b0;
        phase_r    <= PW'(red_sum_nxt);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample_acc) begin
      red_sum_r <= SUMW'(phase_r) + SUMW'(step_r);
    end else if (red_busy_r) begin
      red_sum_r <= red_sum_nxt;
    end
  end

  // divider: DIV_STEP restoring steps per cycle on a narrow remainder
  always_comb begin
    dv = dvd_r;
    rm = rem_r;
    for (int i = 0; i < DIV_STEP; i++) begin
      trial = {rm, dv[DIV_W-1]};
      dv    = {dv[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, harm_eff}) begin
        rm    = HARM_W'(trial - {1'b0, harm_eff});
        dv[0] = 1'b1;
      end else begin
        rm = trial[HARM_W-1:0];
      end
    end
    dvd_nxt = dv;
    rem_nxt = rm;
  end

  always_comb begin
    diff     = $signed({mem_rd_data_r[DATA_W-1], mem_rd_data_r}) -
               $signed({v0_r[DATA_W-1], v0_r});
    frac_s   = $signed({1'b0, frac_r});
    p_nxt    = (34'($signed(v0_r)) <<< FRAC_BITS) + 34'(diff * frac_s);
    full_sum = {pp_hi_r, MUL_SPLIT'(0)} + FULL_W'(pp_lo_r);
    max_pos  = (SATW'(1) << (SAMPLE_BITS - 1)) - SATW'(1);
    sat_mag  = SATW'(raw_r);
    if (neg_r) begin
      if (sat_mag > max_pos + SATW'(1)) begin
        sat_mag = max_pos + SATW'(1);
      end
      sat_res = ~sat_mag + SATW'(1);
    end else begin
      if (sat_mag > max_pos) begin
        sat_mag = max_pos;
      end
      sat_res = sat_mag;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (sample_acc) state_nxt = S_RD1;
      S_RD1:  state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ABS;
      S_ABS:  state_nxt = S_WGT;
      S_WGT:  state_nxt = S_DIV;
      S_DIV:  if (div_cnt_r == DCW'(DIV_CYCLES - 1)) state_nxt = S_GMUL;
      S_GMUL: state_nxt = S_SUM;
      S_SUM:  state_nxt = S_OUT;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DIV) begin
        div_cnt_r <= div_cnt_r + DCW'(1);
      end else begin
        div_cnt_r <= '0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (sample_acc) begin
          idx_r  <= phase_r[PW-1:FRAC_BITS];
          frac_r <= phase_r[FRAC_BITS-1:0];
          gain_r <= in_envelope_gain;
        end
      end
      S_RD1: v0_r <= mem_rd_data_r;
      S_MUL: p_r <= p_nxt;
      S_ABS: begin
        neg_r <= p_r[33];
        mag_r <= p_r[33] ? MAG_W'(-p_r) : MAG_W'(p_r);
      end
      S_WGT: begin
        dvd_r <= DIV_W'(mag_r) * DIV_W'(weight_r);
        rem_r <= '0;
      end
      S_DIV: begin
        dvd_r <= dvd_nxt;
        rem_r <= rem_nxt;
      end
      S_GMUL: begin
        pp_hi_r <= PPROD_W'(dvd_r[DIV_W-1:MUL_SPLIT]) * PPROD_W'(gain_r);
        pp_lo_r <= PPROD_W'(dvd_r[MUL_SPLIT-1:0]) * PPROD_W'(gain_r);
      end
      S_SUM: raw_r <= full_sum[FULL_W-1:GAIN_SHIFT];
      S_OUT: if (out_load) out_sample_r <= sat_res[DATA_W-1:0];
      default: ;
    endcase
  end

  // phase always stays inside the table span
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    64'(phase_r) < 64'(SPAN))
    else $error("phase outside table span");

  // a sample transaction starts the table read sequence
  a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_SAMPLE) |=> (state_r == S_RD1))
    else $error("sample transaction did not start a read");

  // a write transaction never produces a result
  a_write_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_command == CMD_WRITE) |=> (state_r == S_IDLE))
    else $error("write transaction left idle");

  // the phase advance is complete before the result is loaded
  a_phase_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT) |-> !red_busy_r)
    else $error("phase reduction still running at output");

endmodule
